>>> hdl/brf_pkg.sv
// Package: shared constants, codes and command types of the byte ring FIFO.
`timescale 1ns / 1ps
`default_nettype none
package brf_pkg;

  localparam int STORE_DEPTH    = 1024;
  localparam int MAX_READ_BURST = 64;
  localparam int PTR_W          = $clog2(STORE_DEPTH);
  localparam int CNT_W          = 11;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DRAIN = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_REPORT
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EMIT,
    BK_RD_WAIT,
    BK_RD_EMIT
  } bk_state_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       data;
    logic [PTR_W-1:0] addr;
    logic [CNT_W-1:0] moved;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] fill;
    logic [CNT_W-1:0] free;
    logic             full;
  } cmd_t;

endpackage
`default_nettype wire

>>> hdl/brf_ifs.sv
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none
interface brf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  write_byte;
  logic [10:0] byte_count;
  modport source (output valid, operation, write_byte, byte_count, input ready);
  modport sink   (input valid, operation, write_byte, byte_count, output ready);
endinterface

interface brf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic        has_data;
  logic        is_last;
  logic [10:0] moved_count;
  logic [10:0] fill_level;
  logic [10:0] free_space;
  logic        full_flag;
  modport source (output valid, read_byte, has_data, is_last, moved_count, fill_level,
                  free_space, full_flag, input ready);
  modport sink   (input valid, read_byte, has_data, is_last, moved_count, fill_level,
                  free_space, full_flag, output ready);
endinterface

interface brf_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] capacity_in_use;
  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface
`default_nettype wire

>>> hdl/brf_front.sv
// Front end: accepts requests, tracks pointers and fill, issues commands.
`timescale 1ns / 1ps
`default_nettype none
module brf_front (
  input  wire logic      clk,
  input  wire logic      rst_n,
  brf_in_if.sink         in_ch,
  brf_cfg_if.sink        cfg_ch,
  input  wire logic      q_full,
  output logic           q_push,
  output brf_pkg::cmd_t  q_cmd
);

  logic [brf_pkg::CNT_W-1:0] cap_r, cap_nxt;
  logic [brf_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [brf_pkg::PTR_W-1:0] rp_r, rp_nxt;
  logic [brf_pkg::PTR_W-1:0] wp_r, wp_nxt;

  logic                      accept;
  logic [brf_pkg::CNT_W-1:0] cap_eff;
  logic [brf_pkg::CNT_W-1:0] clip_fill;
  logic [brf_pkg::CNT_W-1:0] n_move;
  logic [brf_pkg::CNT_W-1:0] wp_inc;
  logic [brf_pkg::CNT_W:0]   rp_sum;
  logic [brf_pkg::CNT_W:0]   rp_wrap;
  brf_pkg::op_t              op;

  assign in_ch.ready  = !q_full && !cfg_ch.valid;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign op           = brf_pkg::op_t'(in_ch.operation);

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = brf_pkg::CNT_W'(1);
    end else if (cap_r > brf_pkg::CNT_W'(brf_pkg::STORE_DEPTH)) begin
      cap_eff = brf_pkg::CNT_W'(brf_pkg::STORE_DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  always_comb begin
    clip_fill = (in_ch.byte_count < fill_r) ? in_ch.byte_count : fill_r;
    if (op == brf_pkg::OP_READ && clip_fill > brf_pkg::CNT_W'(brf_pkg::MAX_READ_BURST)) begin
      n_move = brf_pkg::CNT_W'(brf_pkg::MAX_READ_BURST);
    end else begin
      n_move = clip_fill;
    end
    wp_inc  = brf_pkg::CNT_W'(wp_r) + brf_pkg::CNT_W'(1);
    rp_sum  = {1'b0, brf_pkg::CNT_W'(rp_r)} + {1'b0, n_move};
    rp_wrap = (rp_sum >= {1'b0, cap_eff}) ? (rp_sum - {1'b0, cap_eff}) : rp_sum;
  end

  always_comb begin
    cap_nxt  = cap_r;
    fill_nxt = fill_r;
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    q_cmd.kind  = brf_pkg::CMD_REPORT;
    q_cmd.data  = in_ch.write_byte;
    q_cmd.addr  = rp_r;
    q_cmd.moved = '0;
    q_cmd.cap   = cap_eff;
    if (cfg_ch.valid) begin
      cap_nxt  = cfg_ch.capacity_in_use;
      fill_nxt = '0;
      rp_nxt   = '0;
      wp_nxt   = '0;
    end else if (accept) begin
      case (op)
        brf_pkg::OP_WRITE: begin
          if (fill_r < cap_eff) begin
            q_cmd.kind  = brf_pkg::CMD_WRITE;
            q_cmd.addr  = wp_r;
            q_cmd.moved = brf_pkg::CNT_W'(1);
            fill_nxt    = fill_r + brf_pkg::CNT_W'(1);
            wp_nxt      = (wp_inc == cap_eff) ? '0 : wp_inc[brf_pkg::PTR_W-1:0];
          end
        end
        brf_pkg::OP_READ, brf_pkg::OP_DRAIN: begin
          if (op == brf_pkg::OP_READ && n_move != '0) begin
            q_cmd.kind = brf_pkg::CMD_READ;
          end
          q_cmd.moved = n_move;
          fill_nxt    = fill_r - n_move;
          rp_nxt      = rp_wrap[brf_pkg::PTR_W-1:0];
        end
        brf_pkg::OP_CLEAR: begin
          fill_nxt = '0;
          rp_nxt   = '0;
          wp_nxt   = '0;
        end
        default: begin
          fill_nxt = fill_r;
        end
      endcase
    end
    q_cmd.fill = fill_nxt;
    q_cmd.free = cap_eff - fill_nxt;
    q_cmd.full = (fill_nxt == cap_eff);
  end

  assign q_push = accept && !cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= brf_pkg::CNT_W'(brf_pkg::STORE_DEPTH);
      fill_r <= '0;
      rp_r   <= '0;
      wp_r   <= '0;
    end else begin
      cap_r  <= cap_nxt;
      fill_r <= fill_nxt;
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/brf_cmd_queue.sv
// Command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module brf_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire brf_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               valid,
  output brf_pkg::cmd_t      pop_cmd
);

  brf_pkg::cmd_t              entry_r [brf_pkg::QUEUE_DEPTH];
  logic [brf_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [brf_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [brf_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                       do_push, do_pop;

  assign full    = (count_r == (brf_pkg::QPTR_W+1)'(brf_pkg::QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign pop_cmd = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == brf_pkg::QPTR_W'(brf_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + brf_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == brf_pkg::QPTR_W'(brf_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + brf_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (brf_pkg::QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (brf_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/brf_back.sv
// Back end: byte store, command execution and result register.
`timescale 1ns / 1ps
`default_nettype none
module brf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire brf_pkg::cmd_t q_cmd,
  output logic               q_pop,
  brf_out_if.source          out_ch
);

  logic [7:0]                store_mem [brf_pkg::STORE_DEPTH];
  logic [7:0]                mem_q_r;

  brf_pkg::bk_state_t        state_r, state_nxt;
  brf_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [brf_pkg::PTR_W-1:0] addr_r, addr_nxt;
  logic [brf_pkg::CNT_W-1:0] left_r, left_nxt;
  logic [brf_pkg::CNT_W-1:0] addr_inc;

  logic                      slot_free;
  logic                      load_out;
  logic                      mem_we;
  logic                      last_byte;

  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                read_byte_r, read_byte_nxt;
  logic                      has_data_r, has_data_nxt;
  logic                      is_last_r, is_last_nxt;
  logic [brf_pkg::CNT_W-1:0] moved_r, moved_nxt;
  logic [brf_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [brf_pkg::CNT_W-1:0] free_r, free_nxt;
  logic                      full_r, full_nxt;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign last_byte = (left_r == brf_pkg::CNT_W'(1));
  assign addr_inc  = brf_pkg::CNT_W'(addr_r) + brf_pkg::CNT_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brf_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_cmd.kind == brf_pkg::CMD_READ) ? brf_pkg::BK_RD_WAIT
                      : brf_pkg::BK_EMIT;
        end
      end
      brf_pkg::BK_EMIT: begin
        if (slot_free) begin
          state_nxt = brf_pkg::BK_IDLE;
        end
      end
      brf_pkg::BK_RD_WAIT: begin
        state_nxt = brf_pkg::BK_RD_EMIT;
      end
      brf_pkg::BK_RD_EMIT: begin
        if (slot_free) begin
          state_nxt = last_byte ? brf_pkg::BK_IDLE : brf_pkg::BK_RD_WAIT;
        end
      end
      default: begin
        state_nxt = brf_pkg::BK_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop         = 1'b0;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    left_nxt      = left_r;
    read_byte_nxt = read_byte_r;
    has_data_nxt  = has_data_r;
    is_last_nxt   = is_last_r;
    moved_nxt     = moved_r;
    fill_nxt      = fill_r;
    free_nxt      = free_r;
    full_nxt      = full_r;
    case (state_r)
      brf_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_cmd;
          addr_nxt = q_cmd.addr;
          left_nxt = q_cmd.moved;
        end
      end
      brf_pkg::BK_EMIT: begin
        if (slot_free) begin
          load_out      = 1'b1;
          mem_we        = (cmd_r.kind == brf_pkg::CMD_WRITE);
          read_byte_nxt = '0;
          has_data_nxt  = 1'b0;
          is_last_nxt   = 1'b1;
          moved_nxt     = cmd_r.moved;
        end
      end
      brf_pkg::BK_RD_EMIT: begin
        if (slot_free) begin
          load_out      = 1'b1;
          read_byte_nxt = mem_q_r;
          has_data_nxt  = 1'b1;
          is_last_nxt   = last_byte;
          moved_nxt     = last_byte ? cmd_r.moved : '0;
          addr_nxt      = (addr_inc == cmd_r.cap) ? '0 : addr_inc[brf_pkg::PTR_W-1:0];
          left_nxt      = left_r - brf_pkg::CNT_W'(1);
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
    if (load_out) begin
      fill_nxt = cmd_r.fill;
      free_nxt = cmd_r.free;
      full_nxt = cmd_r.full;
    end
    out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[cmd_r.addr] <= cmd_r.data;
    end
    mem_q_r <= store_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brf_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    left_r      <= left_nxt;
    read_byte_r <= read_byte_nxt;
    has_data_r  <= has_data_nxt;
    is_last_r   <= is_last_nxt;
    moved_r     <= moved_nxt;
    fill_r      <= fill_nxt;
    free_r      <= free_nxt;
    full_r      <= full_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_byte   = read_byte_r;
  assign out_ch.has_data    = has_data_r;
  assign out_ch.is_last     = is_last_r;
  assign out_ch.moved_count = moved_r;
  assign out_ch.fill_level  = fill_r;
  assign out_ch.free_space  = free_r;
  assign out_ch.full_flag   = full_r;

endmodule
`default_nettype wire

>>> hdl/byte_ring_fifo_unit.sv
// Path: a request goes through the command queue and the back end's command register to the
// result register; each byte of a read also passes the registered read of the byte store.
// The back end runs one command at a time; the two-entry queue takes requests until it is full.
// Reset (rst_n, synchronous): pointers, fill and queue clear, capacity returns to 1024;
// store contents are kept and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module byte_ring_fifo_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch,
  brf_cfg_if.sink   cfg_ch
);

  logic          push, q_full, q_valid, q_pop;
  brf_pkg::cmd_t push_cmd, pop_cmd;

  brf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (push),
    .q_cmd  (push_cmd)
  );

  brf_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  brf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

>>> hdl/brf_checker.sv
// Checker on the result port of the byte ring FIFO, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module brf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  read_byte,
  input wire logic        has_data,
  input wire logic        is_last,
  input wire logic [10:0] moved_count,
  input wire logic [10:0] free_space,
  input wire logic        full_flag
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_burst_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_last |-> has_data)
    else $error("non-last result without data");

  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_data |-> is_last && read_byte == 8'd0)
    else $error("empty result malformed");

  a_moved_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_last |-> moved_count == 11'd0)
    else $error("moved count before last result");

  a_full_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && full_flag |-> free_space == 11'd0)
    else $error("full with free space");

endmodule

bind byte_ring_fifo_unit brf_checker u_brf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .read_byte   (out_ch.read_byte),
  .has_data    (out_ch.has_data),
  .is_last     (out_ch.is_last),
  .moved_count (out_ch.moved_count),
  .free_space  (out_ch.free_space),
  .full_flag   (out_ch.full_flag)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the circular byte FIFO unit: random and directed requests.
`timescale 1ns / 1ps
module tb;
  import brf_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        has_data;
    logic        is_last;
    logic [10:0] moved_count;
    logic [10:0] fill_level;
    logic [10:0] free_space;
    logic        full_flag;
  } fifo_result_t;

  class ring_fifo_shadow;
    logic [7:0]   byte_mem [STORE_DEPTH];
    int unsigned  rd_ptr, wr_ptr, fill, cap_reg;
    fifo_result_t results_due [$];
    int unsigned  failures, n_requests, n_results, n_drops, n_long_reads, n_cap_writes;

    function new();
      cap_reg = STORE_DEPTH;
    endfunction

    function int unsigned cap_eff();
      if (cap_reg == 0) return 1;
      if (cap_reg > STORE_DEPTH) return STORE_DEPTH;
      return cap_reg;
    endfunction

    function void set_capacity(logic [10:0] v);
      cap_reg = v;
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
      n_cap_writes++;
    endfunction

    function void due(logic [7:0] b, logic has, logic last, int unsigned moved,
                      int unsigned cap);
      fifo_result_t r;
      r.read_byte   = b;
      r.has_data    = has;
      r.is_last     = last;
      r.moved_count = 11'(moved);
      r.fill_level  = 11'(fill);
      r.free_space  = 11'(cap - fill);
      r.full_flag   = (fill == cap);
      results_due.push_back(r);
    endfunction

    function void apply_request(op_t op, logic [7:0] wb, logic [10:0] cnt);
      int unsigned cap, n;
      logic [7:0] burst [$];
      cap = cap_eff();
      n_requests++;
      case (op)
        OP_WRITE: begin
          n = 0;
          if (fill < cap) begin
            byte_mem[wr_ptr] = wb;
            wr_ptr = (wr_ptr + 1) % cap;
            fill++;
            n = 1;
          end else begin
            n_drops++;
          end
          due(8'h00, 1'b0, 1'b1, n, cap);
        end
        OP_READ: begin
          n = cnt;
          if (n > fill) n = fill;
          if (n > MAX_READ_BURST) begin
            n = MAX_READ_BURST;
            n_long_reads++;
          end
          for (int unsigned i = 0; i < n; i++) begin
            burst.push_back(byte_mem[rd_ptr]);
            rd_ptr = (rd_ptr + 1) % cap;
          end
          fill -= n;
          if (n == 0) due(8'h00, 1'b0, 1'b1, 0, cap);
          foreach (burst[i])
            due(burst[i], 1'b1, i == n - 1, (i == n - 1) ? n : 0, cap);
        end
        OP_DRAIN: begin
          n = cnt;
          if (n > fill) n = fill;
          rd_ptr = (rd_ptr + n) % cap;
          fill -= n;
          due(8'h00, 1'b0, 1'b1, n, cap);
        end
        default: begin
          rd_ptr = 0;
          wr_ptr = 0;
          fill = 0;
          due(8'h00, 1'b0, 1'b1, 0, cap);
        end
      endcase
    endfunction

    function string show(fifo_result_t r);
      return $sformatf("byte %h has %b last %b moved %0d fill %0d free %0d full %b",
                       r.read_byte, r.has_data, r.is_last, r.moved_count,
                       r.fill_level, r.free_space, r.full_flag);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MAX_SHOWN) $display("MISMATCH: %s", msg);
    endfunction

    function void match_result(fifo_result_t got);
      fifo_result_t want;
      n_results++;
      if (results_due.size() == 0) begin
        flag({"result with no request pending: ", show(got)});
        return;
      end
      want = results_due.pop_front();
      if (got.read_byte !== want.read_byte || got.has_data !== want.has_data ||
          got.is_last !== want.is_last || got.moved_count !== want.moved_count ||
          got.fill_level !== want.fill_level || got.free_space !== want.free_space ||
          got.full_flag !== want.full_flag)
        flag($sformatf("result %0d expected [%s] got [%s]", n_results, show(want),
                       show(got)));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   tx_idle_en = 1'b1;
  bit   rx_idle_en = 1'b1;
  int unsigned hold_request = 0;
  int unsigned quiet_cycles = 0;

  brf_in_if  in_ch ();
  brf_out_if out_ch ();
  brf_cfg_if cfg_ch ();

  ring_fifo_shadow shadow = new();

  byte_ring_fifo_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      shadow.match_result(fifo_result_t'{out_ch.read_byte, out_ch.has_data, out_ch.is_last,
                                         out_ch.moved_count, out_ch.fill_level,
                                         out_ch.free_space, out_ch.full_flag});
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(rx_idle_en && $urandom_range(99) < 18);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TIMEOUT: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, shadow.results_due.size());
      $display("** byte_ring_fifo_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input op_t op, input logic [7:0] wb, input logic [10:0] cnt);
    while (tx_idle_en && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.write_byte <= wb;
    in_ch.byte_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
    shadow.apply_request(op, wb, cnt);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (shadow.results_due.size() != 0);
  endtask

  task automatic write_capacity(input logic [10:0] v);
    settle();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.capacity_in_use <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow.set_capacity(v);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned r;
    op_t op;
    logic [10:0] cnt;
    r = $urandom_range(99);
    if (r < 50) op = OP_WRITE;
    else if (r < 78) op = OP_READ;
    else if (r < 95) op = OP_DRAIN;
    else op = OP_CLEAR;
    r = $urandom_range(99);
    if (r < 8) cnt = '0;
    else if (r < 75) cnt = 11'($urandom_range(shadow.fill + 2, 1));
    else if (r < 90) cnt = 11'($urandom_range(2047, 0));
    else cnt = 11'($urandom_range(70, 60));
    send_request(op, 8'($urandom), cnt);
  endtask

  initial begin
    logic [10:0] caps [10];
    logic [10:0] v;
    caps = '{11'd3, 11'd1, 11'd2, 11'd64, 11'd16, 11'd1024, 11'd1025, 11'd0, 11'd5, 11'd0};
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.operation        <= OP_WRITE;
    in_ch.write_byte       <= 8'h00;
    in_ch.byte_count       <= 11'd0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.capacity_in_use <= 11'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty buffer, extremes, clipping, clear, tiny and out-of-range capacity
    send_request(OP_READ,  8'h00, 11'd0);
    send_request(OP_DRAIN, 8'h00, 11'd1024);
    send_request(OP_WRITE, 8'h00, 11'd0);
    send_request(OP_WRITE, 8'hFF, 11'd2047);
    send_request(OP_WRITE, 8'hA5, 11'd0);
    send_request(OP_WRITE, 8'h5A, 11'd0);
    send_request(OP_READ,  8'h00, 11'd0);
    send_request(OP_READ,  8'h00, 11'd1);
    send_request(OP_DRAIN, 8'h00, 11'd1);
    send_request(OP_READ,  8'hFF, 11'd2047);
    send_request(OP_WRITE, 8'h33, 11'd0);
    send_request(OP_CLEAR, 8'h00, 11'd0);
    send_request(OP_READ,  8'h00, 11'd5);
    send_request(OP_WRITE, 8'h80, 11'd0);
    write_capacity(11'd1);
    send_request(OP_WRITE, 8'h11, 11'd0);
    send_request(OP_WRITE, 8'h22, 11'd0);
    send_request(OP_READ,  8'h00, 11'd1);
    send_request(OP_DRAIN, 8'h00, 11'd0);
    write_capacity(11'd0);
    send_request(OP_WRITE, 8'h44, 11'd0);
    send_request(OP_WRITE, 8'h55, 11'd0);
    send_request(OP_DRAIN, 8'h00, 11'd2047);
    write_capacity(11'd2047);
    send_request(OP_WRITE, 8'h66, 11'd0);
    send_request(OP_READ,  8'h00, 11'd1);

    // receiver holds off while writes keep coming, then long reads
    write_capacity(11'd1024);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_request = 300;
    repeat (80) send_request(OP_WRITE, 8'($urandom), 11'($urandom));
    send_request(OP_READ, 8'h00, 11'd2047);
    send_request(OP_READ, 8'h00, 11'd100);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    for (int k = 0; k < 10; k++) begin
      v = (k == 9) ? 11'($urandom_range(1024, 1)) : caps[k];
      write_capacity(v);
      tx_idle_en = (k != 3);
      rx_idle_en = (k != 3);
      for (int i = 0; i < 36; i++) begin
        if (i == 18) settle();
        random_request();
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    settle();
    repeat (10) @(posedge clk);
    if (shadow.results_due.size() != 0)
      shadow.flag($sformatf("%0d results never arrived", shadow.results_due.size()));
    $display("Covered %0d requests, %0d results, %0d capacity writes incl. 0, 1 and 2047.",
             shadow.n_requests, shadow.n_results, shadow.n_cap_writes);
    $display("%0d writes dropped on a full buffer, %0d reads clipped to the burst limit.",
             shadow.n_drops, shadow.n_long_reads);
    if (shadow.failures == 0) begin
      $display("** byte_ring_fifo_unit: PASSED **");
    end else begin
      $display("%0d mismatches", shadow.failures);
      $display("** byte_ring_fifo_unit: FAILED **");
    end
    $finish;
  end

endmodule
